// ----- rtl/mscc_pkg.sv -----
// Shared types and constants for the MIPS subset core.
// Holds the channel word layouts, instruction codes and the register write bundle.
// No dependencies; compile first.
`default_nettype none

package mscc_pkg;

   localparam int unsigned REG_COUNT = 32;
   localparam int unsigned REG_IDX_W = 5;

   // item operation codes on the request channel
   localparam logic [1:0] OP_PRELOAD_MEM = 2'd0;
   localparam logic [1:0] OP_PRELOAD_REG = 2'd1;
   localparam logic [1:0] OP_EXECUTE     = 2'd2;

   // primary opcodes
   localparam logic [5:0] OPC_RTYPE = 6'd0;
   localparam logic [5:0] OPC_J     = 6'd2;
   localparam logic [5:0] OPC_BEQ   = 6'd4;
   localparam logic [5:0] OPC_LW    = 6'd35;
   localparam logic [5:0] OPC_SW    = 6'd43;

   // R-type function codes
   localparam logic [5:0] FN_ADD = 6'd32;
   localparam logic [5:0] FN_SUB = 6'd34;
   localparam logic [5:0] FN_AND = 6'd36;
   localparam logic [5:0] FN_OR  = 6'd37;
   localparam logic [5:0] FN_SLT = 6'd42;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  address;
      logic [4:0]  reg_sel;
      logic [31:0] data;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] pc_value;
      logic [31:0] instruction;
      logic        reg_written;
      logic [4:0]  reg_dest;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [5:0]  mem_addr;
      logic        halted;
      logic        addr_fault;
   } rsp_payload_type;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [31:0]          data;
   } rf_wr_type;

endpackage

`default_nettype wire

// ----- rtl/mscc_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
// Payload types come from mscc_pkg; a word moves when valid and ready are both high.
`default_nettype none

interface mscc_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/mscc_store.sv -----
// Unified word store: one write port, two registered read ports.
// Port A forwards a same-cycle write to its address; port B holds its data when not enabled.
`default_nettype none

module mscc_store #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_a_addr,
   output logic [31:0]   rd_a_data,
   input  logic          rd_b_en,
   input  logic [AW-1:0] rd_b_addr,
   output logic [31:0]   rd_b_data
);

   logic [31:0] store_ff [DEPTH];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      // write-first on port A so the prefetch never goes stale
      if (wr_en && (wr_addr == rd_a_addr)) begin
         rd_a_ff <= wr_data;
      end else begin
         rd_a_ff <= store_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= store_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ----- rtl/mscc_regfile.sv -----
// General register file: 32 words, one write port, two registered read ports.
// Reads forward a same-cycle write. Uses mscc_pkg for the write bundle.
`default_nettype none

module mscc_regfile (
   input  logic                               clock,
   input  mscc_pkg::rf_wr_type                wr,
   input  logic [mscc_pkg::REG_IDX_W-1:0]     rd_a_idx,
   input  logic [mscc_pkg::REG_IDX_W-1:0]     rd_b_idx,
   output logic [31:0]                        rd_a_data,
   output logic [31:0]                        rd_b_data
);
   import mscc_pkg::*;

   logic [31:0] regs_ff [REG_COUNT];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx] <= wr.data;
      end
      rd_a_ff <= (wr.en && (wr.idx == rd_a_idx)) ? wr.data : regs_ff[rd_a_idx];
      rd_b_ff <= (wr.en && (wr.idx == rd_b_idx)) ? wr.data : regs_ff[rd_b_idx];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ----- rtl/mips_single_cycle_core_unit.sv -----
// MIPS subset core: preload and execute items in, one result word out per item.
// Depends on mscc_pkg, mscc_chan_if, mscc_store and mscc_regfile.
//
//   channel    dir  modport  word                          moves when
//   req_chan   in   sink     mscc_pkg::req_payload_type    valid && ready
//   rsp_chan   out  source   mscc_pkg::rsp_payload_type    valid && ready
//
// Rate: one word per cycle for preloads and straight-line instructions while rsp
// takes words; after a taken beq or a j, req ready stays low while the fetch register
// refills from store port B. A request word is executed as it is taken; its result
// word then passes the writeback stage and the result register, which drives rsp.
// Reset: synchronous; then a clearing pass over addresses 0 to max(MEM_WORDS, 32) - 1
// zeroes the store and the register file with req ready low.
// Stalls: the writeback stage and the result register part the two sides; apart from
// the clearing pass and a refill, req ready drops only while the writeback stage
// cannot move on.
`default_nettype none

module mips_single_cycle_core_unit #(
   parameter int unsigned MEM_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   mscc_chan_if.sink   req_chan,
   mscc_chan_if.source rsp_chan
);
   import mscc_pkg::*;

   localparam int unsigned AW        = $clog2(MEM_WORDS);
   localparam int unsigned CLR_DEPTH = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
   localparam int unsigned CW        = $clog2(CLR_DEPTH);
   localparam logic [31:0]   MEM_LIMIT   = 32'(MEM_WORDS);
   localparam logic [CW:0]   CLR_MEM_END = (CW+1)'(MEM_WORDS);
   localparam logic [CW:0]   CLR_RF_END  = (CW+1)'(REG_COUNT);
   localparam logic [CW-1:0] CLR_LAST    = CW'(CLR_DEPTH - 1);

   typedef enum logic [1:0] {
      FS_CLEAR,
      FS_REFILL,
      FS_READY
   } fetch_state_type;

   // fetch and sequencing state
   fetch_state_type state_ff, state_in;
   logic [CW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [31:0]     pc_ff, pc_in;
   logic [31:0]     fa_ff, fa_in;          // instruction word at pc_ff

   // writeback stage and result register
   logic            w_valid_ff, w_valid_in;
   logic            w_load_ff;
   rsp_payload_type w_ff, w_in, w_out;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   // memory ports
   logic          st_wr_en;
   logic [AW-1:0] st_wr_addr;
   logic [31:0]   st_wr_data;
   logic [AW-1:0] st_rda_addr;
   logic [31:0]   st_rda;                   // word at pc_ff + 4
   logic          st_rdb_en;
   logic [AW-1:0] st_rdb_addr;
   logic [31:0]   st_rdb;                   // load data or redirect target word
   rf_wr_type     rf_wr;
   logic [31:0]   rf_rda, rf_rdb;

   // execute stage
   req_payload_type p;
   logic            accept, w_adv, req_ready;
   logic [5:0]      opc, fn;
   logic [4:0]      rs, rt, rd;
   logic [31:0]     imm, pc4, pc_in4, ea, op_a, op_b, alu_res;
   logic            alu_ok;
   logic [31:0]     e_next_pc;
   logic            e_seq, e_redirect, e_load, e_st_en;
   logic [AW-1:0]   e_st_addr;
   logic [31:0]     e_st_data;

   assign p      = req_chan.payload;
   assign w_adv  = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == FS_READY) && (!w_valid_ff || w_adv);
   assign req_chan.ready = req_ready;
   assign accept = req_chan.valid && req_ready;

   // decode the prefetched word
   assign opc = fa_ff[31:26];
   assign rs  = fa_ff[25:21];
   assign rt  = fa_ff[20:16];
   assign rd  = fa_ff[15:11];
   assign fn  = fa_ff[5:0];
   assign imm = {{16{fa_ff[15]}}, fa_ff[15:0]};
   assign pc4 = pc_ff + 32'd4;

   // the writeback stage's register write has not reached the file yet: forward it
   always_comb begin
      w_out = w_ff;
      if (w_load_ff) begin
         w_out.reg_value = st_rdb;
      end
   end

   assign op_a = (w_valid_ff && w_ff.reg_written && (w_ff.reg_dest == rs))
                 ? w_out.reg_value : rf_rda;
   assign op_b = (w_valid_ff && w_ff.reg_written && (w_ff.reg_dest == rt))
                 ? w_out.reg_value : rf_rdb;
   assign ea   = op_a + imm;

   always_comb begin
      alu_ok  = 1'b1;
      alu_res = '0;
      case (fn)
         FN_ADD:  alu_res = op_a + op_b;
         FN_SUB:  alu_res = op_a - op_b;
         FN_AND:  alu_res = op_a & op_b;
         FN_OR:   alu_res = op_a | op_b;
         FN_SLT:  alu_res = {31'd0, $signed(op_a) < $signed(op_b)};
         default: alu_ok  = 1'b0;
      endcase
   end

   // execute: work out the result word and the side effects of the item on req
   always_comb begin
      e_next_pc  = pc_ff;
      e_seq      = 1'b0;
      e_redirect = 1'b0;
      e_load     = 1'b0;
      e_st_en    = 1'b0;
      e_st_addr  = AW'(p.address);
      e_st_data  = p.data;
      w_in       = '0;
      case (p.opcode)
         OP_PRELOAD_MEM: begin
            if ({26'd0, p.address} < MEM_LIMIT) begin
               e_st_en           = 1'b1;
               w_in.mem_written  = 1'b1;
               w_in.mem_addr     = p.address;
            end else begin
               w_in.addr_fault = 1'b1;
            end
         end
         OP_PRELOAD_REG: begin
            // register zero is hard-wired: drop the write
            if (p.reg_sel != '0) begin
               w_in.reg_written = 1'b1;
               w_in.reg_dest    = p.reg_sel;
               w_in.reg_value   = p.data;
            end
         end
         OP_EXECUTE: begin
            // a halted core leaves everything as it is
            if (pc_ff < MEM_LIMIT) begin
               w_in.instruction = fa_ff;
               e_next_pc        = pc4;
               e_seq            = 1'b1;
               case (opc)
                  OPC_RTYPE: begin
                     if (alu_ok && (rd != '0)) begin
                        w_in.reg_written = 1'b1;
                        w_in.reg_dest    = rd;
                        w_in.reg_value   = alu_res;
                     end
                  end
                  OPC_LW, OPC_SW: begin
                     if (ea >= MEM_LIMIT) begin
                        w_in.addr_fault = 1'b1;
                     end else if (opc == OPC_LW) begin
                        // data arrives from port B during writeback
                        if (rt != '0) begin
                           e_load           = 1'b1;
                           w_in.reg_written = 1'b1;
                           w_in.reg_dest    = rt;
                        end
                     end else begin
                        e_st_en          = 1'b1;
                        e_st_addr        = ea[AW-1:0];
                        e_st_data        = op_b;
                        w_in.mem_written = 1'b1;
                        w_in.mem_addr    = ea[5:0];
                     end
                  end
                  OPC_BEQ: begin
                     if (op_a == op_b) begin
                        e_next_pc  = pc4 + {imm[29:0], 2'b00};
                        e_seq      = 1'b0;
                        e_redirect = 1'b1;
                     end
                  end
                  OPC_J: begin
                     e_next_pc  = {pc4[31:28], fa_ff[25:0], 2'b00};
                     e_seq      = 1'b0;
                     e_redirect = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      w_in.pc_value = e_next_pc;
      w_in.halted   = e_next_pc >= MEM_LIMIT;
   end

   // memory port steering
   assign pc_in  = accept ? e_next_pc : pc_ff;
   assign pc_in4 = pc_in + 32'd4;

   always_comb begin
      if (state_ff == FS_CLEAR) begin
         st_wr_en   = {1'b0, clr_cnt_ff} < CLR_MEM_END;
         st_wr_addr = AW'(clr_cnt_ff);
         st_wr_data = '0;
         rf_wr.en   = {1'b0, clr_cnt_ff} < CLR_RF_END;
         rf_wr.idx  = clr_cnt_ff[REG_IDX_W-1:0];
         rf_wr.data = '0;
      end else begin
         st_wr_en   = accept && e_st_en;
         st_wr_addr = e_st_addr;
         st_wr_data = e_st_data;
         rf_wr.en   = w_valid_ff && w_adv && w_ff.reg_written;
         rf_wr.idx  = w_ff.reg_dest;
         rf_wr.data = w_out.reg_value;
      end
   end

   assign st_rda_addr = pc_in4[AW-1:0];
   assign st_rdb_en   = accept;
   assign st_rdb_addr = e_load ? ea[AW-1:0] : pc_in[AW-1:0];

   // keep the fetch register on the word at the counter
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      fa_in      = fa_ff;
      case (state_ff)
         FS_CLEAR: begin
            fa_in      = '0;
            clr_cnt_in = clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = FS_READY;
            end
         end
         FS_REFILL: begin
            fa_in    = st_rdb;
            state_in = FS_READY;
         end
         FS_READY: begin
            if (accept && e_redirect) begin
               state_in = FS_REFILL;
            end else if (accept && e_seq) begin
               fa_in = (st_wr_en && (st_wr_addr == pc4[AW-1:0])) ? st_wr_data : st_rda;
            end else if (st_wr_en && (st_wr_addr == pc_ff[AW-1:0])) begin
               fa_in = st_wr_data;
            end
         end
         default: state_in = FS_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FS_CLEAR;
         clr_cnt_ff <= '0;
         pc_ff      <= '0;
         fa_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         pc_ff      <= pc_in;
         fa_ff      <= fa_in;
      end
   end

   // writeback stage, then result register
   always_comb begin
      if (accept) begin
         w_valid_in = 1'b1;
      end else if (w_adv) begin
         w_valid_in = 1'b0;
      end else begin
         w_valid_in = w_valid_ff;
      end
      rsp_valid_in = w_adv ? w_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         w_ff      <= w_in;
         w_load_ff <= e_load;
      end
      if (w_adv && w_valid_ff) begin
         rsp_ff <= w_out;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   mscc_store #(
      .DEPTH (MEM_WORDS),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_wr_en),
      .wr_addr   (st_wr_addr),
      .wr_data   (st_wr_data),
      .rd_a_addr (st_rda_addr),
      .rd_a_data (st_rda),
      .rd_b_en   (st_rdb_en),
      .rd_b_addr (st_rdb_addr),
      .rd_b_data (st_rdb)
   );

   // operands for the word that will sit in the fetch register next cycle
   mscc_regfile u_regfile (
      .clock     (clock),
      .wr        (rf_wr),
      .rd_a_idx  (fa_in[25:21]),
      .rd_b_idx  (fa_in[20:16]),
      .rd_a_data (rf_rda),
      .rd_b_data (rf_rdb)
   );

endmodule

`default_nettype wire
